>>> rtl/was_pkg.sv
// Shared types, constants and control-word layout for the weekly alarm scheduler.
`default_nettype none

package was_pkg;

    localparam int NUM_ALARMS = 10;
    localparam int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

    // item kinds carried in the slave tuser
    localparam logic [1:0] FN_TICK  = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_STOP  = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W  = 2;
    localparam logic [1:0] CFG_WAKE   = 2'd0;
    localparam logic [1:0] CFG_INTV   = 2'd1;
    localparam logic [1:0] CFG_RAMP   = 2'd2;

    localparam logic [31:0] WAKE_RST = 32'd120000;
    localparam logic [31:0] INTV_RST = 32'd10000;
    localparam logic [31:0] RAMP_RST = 32'd84000;

    localparam logic [8:0] NEVER_DAY = 9'h1FF;

    localparam int HOUR_MIN = 60;
    localparam int DAY_MIN  = 1440;
    localparam int WEEK_MIN = 10080;
    localparam int MIN_MS   = 60000;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_LOAD  = 3'd1,
        OP_FUNC  = 3'd2,
        OP_SCAN  = 3'd3,
        OP_SCALE = 3'd4,
        OP_PREP  = 3'd5,
        OP_DIV   = 3'd6,
        OP_EMIT  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        C_NONE     = 2'd0,
        C_NO_IN    = 2'd1,
        C_MORE     = 2'd2,
        C_OUT_BUSY = 2'd3
    } t_cond;

    // one microcode word
    typedef struct packed {
        t_op         op;
        t_cond       cond;
        logic        hold;    // taken jump is a wait: op suppressed
        logic        ret;     // fall-through goes back to step 0
        logic [1:0]  sh;      // divider shift for OP_DIV
        t_step       target;
    } t_ctl;

    // what the sequencer hands the datapath each cycle
    typedef struct packed {
        logic        go;
        t_op         op;
        logic [1:0]  sh;
    } t_issue;

    // jump conditions fed back to the sequencer
    typedef struct packed {
        logic no_in;
        logic more;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
    } t_cfg_wr;

    typedef struct packed {
        logic       en;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
    } t_entry;

    // slave tdata layout, lowest field last
    typedef struct packed {
        logic [5:0]  pad;
        logic [5:0]  entry_minute;
        logic [4:0]  entry_hour;
        logic [2:0]  entry_weekday;
        logic        entry_enable;
        logic [3:0]  entry_index;
        logic [8:0]  year_day_now;
        logic [2:0]  weekday_now;
        logic [5:0]  minute_now;
        logic [4:0]  hour_now;
        logic [31:0] now_ms;
    } t_item;

    // master tdata layout, lowest field last
    typedef struct packed {
        logic [6:0]  pad;
        logic        any_armed;
        logic [29:0] next_ms;
        logic        next_valid;
        logic [2:0]  brightness;
        logic        fired_now;
        logic [3:0]  active_slot;
        logic        alarm_on;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/weekly_alarm_scheduler_core.sv
// Each item runs through accept, function, table scan, scale, prep, three divide steps, emit.
// One item is handled at a time; the table scan checks one entry per cycle, and the
// brightness ramp uses three restoring divider steps.
// A new item is taken while the previous result waits on the master side.
// Reset (synchronous, active low): table disabled, no fired marks, no active alarm,
// configuration at its defaults.
`default_nettype none

module weekly_alarm_scheduler_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata,
    // slave side
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // now_ms[31:0], hour_now[36:32], minute_now[42:37], weekday_now[45:43],
    // year_day_now[54:46], entry_index[58:55], entry_enable[59], entry_weekday[62:60],
    // entry_hour[67:63], entry_minute[73:68], zero[79:74]
    input  wire logic [79:0] i_s_tdata,
    // func[1:0]
    input  wire logic [1:0]  i_s_tuser,
    // master side
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // alarm_on[0], active_slot[4:1], fired_now[5], brightness[8:6], next_valid[9],
    // next_ms[39:10], any_armed[40], zero[47:41]
    output logic [47:0]      o_m_tdata
);

    was_pkg::t_issue  iss;
    was_pkg::t_stat   stat;
    was_pkg::t_cfg_wr cfg;
    was_pkg::t_item   item;
    was_pkg::t_res    res;
    logic             more;
    logic             r_out_valid;
    logic             emit;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_wdata;
    assign item     = i_s_tdata;

    assign o_s_tready = iss.op == was_pkg::OP_LOAD;
    assign emit       = iss.go && (iss.op == was_pkg::OP_EMIT);

    assign stat.no_in    = !i_s_tvalid;
    assign stat.more     = more;
    assign stat.out_busy = r_out_valid && !i_m_tready;

    was_useq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_iss   (iss)
    );

    was_dpath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_iss   (iss),
        .i_cfg   (cfg),
        .i_func  (i_s_tuser),
        .i_item  (item),
        .o_more  (more),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = res;

`ifndef SYNTHESIS
    a_leave_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("sequencer stayed in accept step after taking an item");

    a_bright_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((res.brightness != 3'd0) == res.alarm_on))
        else $error("brightness disagrees with alarm_on");

    a_fired_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && res.fired_now) |-> res.alarm_on)
        else $error("fired_now without an active alarm");

    a_next_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && res.next_valid) |-> res.any_armed)
        else $error("next alarm reported with nothing armed");
`endif

endmodule

`default_nettype wire

>>> rtl/was_useq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`default_nettype none

module was_useq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire was_pkg::t_stat  i_stat,
    output was_pkg::t_issue      o_iss
);

    localparam was_pkg::t_step ST_ACCEPT = 4'd0;
    localparam was_pkg::t_step ST_SCAN   = 4'd2;
    localparam was_pkg::t_step ST_EMIT   = 4'd8;

    function automatic was_pkg::t_ctl mk(was_pkg::t_op op, was_pkg::t_cond cond,
                                         logic hold, logic ret, logic [1:0] sh,
                                         was_pkg::t_step target);
        was_pkg::t_ctl c;
        c.op     = op;
        c.cond   = cond;
        c.hold   = hold;
        c.ret    = ret;
        c.sh     = sh;
        c.target = target;
        return c;
    endfunction

    function automatic was_pkg::t_ctl ucode(was_pkg::t_step s);
        was_pkg::t_ctl c;
        unique case (s)
            4'd0:    c = mk(was_pkg::OP_LOAD,  was_pkg::C_NO_IN,    1'b1, 1'b0, 2'd0, ST_ACCEPT);
            4'd1:    c = mk(was_pkg::OP_FUNC,  was_pkg::C_NONE,     1'b0, 1'b0, 2'd0, ST_ACCEPT);
            4'd2:    c = mk(was_pkg::OP_SCAN,  was_pkg::C_MORE,     1'b0, 1'b0, 2'd0, ST_SCAN);
            4'd3:    c = mk(was_pkg::OP_SCALE, was_pkg::C_NONE,     1'b0, 1'b0, 2'd0, ST_ACCEPT);
            4'd4:    c = mk(was_pkg::OP_PREP,  was_pkg::C_NONE,     1'b0, 1'b0, 2'd0, ST_ACCEPT);
            4'd5:    c = mk(was_pkg::OP_DIV,   was_pkg::C_NONE,     1'b0, 1'b0, 2'd2, ST_ACCEPT);
            4'd6:    c = mk(was_pkg::OP_DIV,   was_pkg::C_NONE,     1'b0, 1'b0, 2'd1, ST_ACCEPT);
            4'd7:    c = mk(was_pkg::OP_DIV,   was_pkg::C_NONE,     1'b0, 1'b0, 2'd0, ST_ACCEPT);
            4'd8:    c = mk(was_pkg::OP_EMIT,  was_pkg::C_OUT_BUSY, 1'b1, 1'b1, 2'd0, ST_EMIT);
            default: c = mk(was_pkg::OP_NOP,   was_pkg::C_NONE,     1'b0, 1'b1, 2'd0, ST_ACCEPT);
        endcase
        return c;
    endfunction

    was_pkg::t_step r_step;
    was_pkg::t_step n_step;
    was_pkg::t_ctl  ctl;
    logic           taken;

    assign ctl = ucode(r_step);

    always_comb begin
        unique case (ctl.cond)
            was_pkg::C_NONE:     taken = 1'b0;
            was_pkg::C_NO_IN:    taken = i_stat.no_in;
            was_pkg::C_MORE:     taken = i_stat.more;
            was_pkg::C_OUT_BUSY: taken = i_stat.out_busy;
        endcase
    end

    always_comb begin
        if (taken) begin
            n_step = ctl.target;
        end else if (ctl.ret) begin
            n_step = ST_ACCEPT;
        end else begin
            n_step = r_step + 4'd1;
        end
    end

    assign o_iss.go = !(taken && ctl.hold);
    assign o_iss.op = ctl.op;
    assign o_iss.sh = ctl.sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_ACCEPT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

>>> rtl/was_dpath.sv
// Datapath: alarm table, fired-day marks, active alarm state, scan and ramp divider.
`default_nettype none

module was_dpath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire was_pkg::t_issue  i_iss,
    input  wire was_pkg::t_cfg_wr i_cfg,
    input  wire logic [1:0]       i_func,
    input  wire was_pkg::t_item   i_item,
    output logic                  o_more,
    output was_pkg::t_res         o_res
);

    localparam logic [was_pkg::IDX_W-1:0] LAST_IDX = was_pkg::IDX_W'(was_pkg::NUM_ALARMS - 1);

    // configuration
    logic [31:0] r_wake, r_intv, r_ramp;

    // architectural state
    was_pkg::t_entry             r_table [was_pkg::NUM_ALARMS];
    logic [8:0]                  r_fday  [was_pkg::NUM_ALARMS];
    logic                        r_active;
    logic [was_pkg::IDX_W-1:0]   r_act_idx;
    logic [31:0]                 r_start;
    logic [31:0]                 r_last;

    // per-item working registers
    logic [1:0]                  r_func;
    was_pkg::t_item              r_item;
    logic [was_pkg::IDX_W-1:0]   r_idx;
    logic                        r_chk;
    logic                        r_found;
    logic                        r_fired;
    logic                        r_armed;
    logic                        r_nvalid;
    logic [13:0]                 r_best;
    logic [10:0]                 r_nmin;
    logic [29:0]                 r_next_ms;
    logic [31:0]                 r_el;
    logic [34:0]                 r_rem;
    logic [2:0]                  r_q;
    logic                        r_sat;

    logic                        go_func, go_scan;
    logic [31:0]                 dif_chk, dif_run;
    logic                        gate, expire;
    was_pkg::t_entry             ent;
    logic                        hit, armed;
    logic signed [4:0]           d_raw;
    logic [2:0]                  days;
    logic [10:0]                 amin;
    logic                        wrap;
    logic [15:0]                 cand;
    logic                        take;
    logic [34:0]                 dv;
    logic                        wr_ok;
    logic [was_pkg::IDX_W-1:0]   wr_idx;

    assign go_func = i_iss.go && (i_iss.op == was_pkg::OP_FUNC);
    assign go_scan = i_iss.go && (i_iss.op == was_pkg::OP_SCAN);

    assign dif_chk = r_item.now_ms - r_last;
    assign gate    = dif_chk >= r_intv;
    assign dif_run = r_item.now_ms - r_start;
    assign expire  = r_active && (dif_run > r_wake);

    assign wr_ok  = {1'b0, r_item.entry_index} < 5'(was_pkg::NUM_ALARMS);
    assign wr_idx = r_item.entry_index[was_pkg::IDX_W-1:0];

    // scan of one table entry
    assign ent = r_table[r_idx];
    assign hit = r_chk && !r_found && !(r_active && (r_act_idx == r_idx)) && ent.en
              && (r_item.year_day_now != r_fday[r_idx])
              && (ent.weekday == r_item.weekday_now)
              && (ent.hour == r_item.hour_now)
              && (ent.minute == r_item.minute_now);
    assign armed = ent.en && (ent.weekday != 3'd0);

    // minutes to the next occurrence; bit 15 is the sign
    assign d_raw = $signed({2'b00, ent.weekday}) - $signed({2'b00, r_item.weekday_now});
    assign days  = (d_raw < 0) ? 3'(d_raw + 5'sd7) : d_raw[2:0];
    assign amin  = 11'(ent.hour) * 11'(was_pkg::HOUR_MIN) + 11'(ent.minute);
    assign wrap  = (days == 3'd0) && (amin <= r_nmin);
    assign cand  = 16'(days) * 16'(was_pkg::DAY_MIN) + 16'(amin) - 16'(r_nmin)
                 + (wrap ? 16'(was_pkg::WEEK_MIN) : 16'd0);
    assign take  = armed && !cand[15] && (!r_nvalid || (cand[13:0] < r_best));

    assign o_more = r_idx != LAST_IDX;

    assign dv = 35'(r_ramp) << i_iss.sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake <= was_pkg::WAKE_RST;
            r_intv <= was_pkg::INTV_RST;
            r_ramp <= was_pkg::RAMP_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                was_pkg::CFG_WAKE: r_wake <= i_cfg.data;
                was_pkg::CFG_INTV: r_intv <= i_cfg.data;
                was_pkg::CFG_RAMP: r_ramp <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < was_pkg::NUM_ALARMS; i++) begin
                r_table[i] <= '0;
                r_fday[i]  <= was_pkg::NEVER_DAY;
            end
            r_active  <= 1'b0;
            r_act_idx <= '0;
            r_start   <= '0;
            r_last    <= '0;
        end else if (go_func) begin
            unique case (r_func)
                was_pkg::FN_TICK: begin
                    if (gate) begin
                        r_last <= r_item.now_ms;
                        if (expire) begin
                            r_active <= 1'b0;
                        end
                    end
                end
                was_pkg::FN_WRITE: begin
                    for (int i = 0; i < was_pkg::NUM_ALARMS; i++) begin
                        r_fday[i] <= was_pkg::NEVER_DAY;
                    end
                    r_active  <= 1'b0;
                    r_act_idx <= '0;
                    r_start   <= '0;
                    if (wr_ok) begin
                        r_table[wr_idx] <= {r_item.entry_enable, r_item.entry_weekday,
                                            r_item.entry_hour, r_item.entry_minute};
                    end
                end
                was_pkg::FN_STOP: begin
                    r_active <= 1'b0;
                end
                default: ;
            endcase
        end else if (go_scan && hit) begin
            r_active      <= 1'b1;
            r_act_idx     <= r_idx;
            r_fday[r_idx] <= r_item.year_day_now;
            r_start       <= r_item.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (go_func) begin
            r_idx <= '0;
        end else if (go_scan && o_more) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_iss.go) begin
            unique case (i_iss.op)
                was_pkg::OP_LOAD: begin
                    r_func <= i_func;
                    r_item <= i_item;
                end
                was_pkg::OP_FUNC: begin
                    r_chk    <= (r_func == was_pkg::FN_TICK) && gate;
                    r_found  <= 1'b0;
                    r_fired  <= 1'b0;
                    r_armed  <= 1'b0;
                    r_nvalid <= 1'b0;
                    r_nmin   <= 11'(r_item.hour_now) * 11'(was_pkg::HOUR_MIN)
                              + 11'(r_item.minute_now);
                end
                was_pkg::OP_SCAN: begin
                    if (hit) begin
                        r_found <= 1'b1;
                        r_fired <= 1'b1;
                    end
                    if (armed) begin
                        r_armed <= 1'b1;
                    end
                    if (take) begin
                        r_best   <= cand[13:0];
                        r_nvalid <= 1'b1;
                    end
                end
                was_pkg::OP_SCALE: begin
                    r_next_ms <= 30'(r_best) * 30'(was_pkg::MIN_MS);
                    r_el      <= dif_run;
                end
                was_pkg::OP_PREP: begin
                    r_rem <= 35'({r_el, 2'b00}) + 35'({r_el, 1'b0});
                    r_sat <= r_el >= r_ramp;
                    r_q   <= '0;
                end
                was_pkg::OP_DIV: begin
                    // one restoring step of el*6 / ramp
                    if (r_rem >= dv) begin
                        r_rem          <= r_rem - dv;
                        r_q[i_iss.sh]  <= 1'b1;
                    end
                end
                was_pkg::OP_EMIT: begin
                    o_res.pad         <= '0;
                    o_res.alarm_on    <= r_active;
                    o_res.active_slot <= r_active ? 4'(r_act_idx) : 4'd0;
                    o_res.fired_now   <= r_fired;
                    o_res.brightness  <= !r_active ? 3'd0 : (r_sat ? 3'd7 : r_q + 3'd1);
                    o_res.next_valid  <= r_nvalid;
                    o_res.next_ms     <= r_nvalid ? r_next_ms : 30'd0;
                    o_res.any_armed   <= r_armed;
                end
                was_pkg::OP_NOP: ;
            endcase
        end
    end

endmodule

`default_nettype wire
